// File: src/esd_pkg.sv
// ---------------------------------------------------------------------------
// esd_pkg
// Shared types and constants for the escape sequence deframer.
// ---------------------------------------------------------------------------
`default_nettype none

package esd_pkg;

    localparam logic [7:0] ESC_BYTE   = 8'h1b;
    localparam logic [7:0] START_BYTE = 8'h01;
    localparam logic [7:0] STOP_BYTE  = 8'h1a;

    // Last value of the run counter before a four-byte run completes.
    localparam logic [1:0] RUN_LAST = 2'd3;

    typedef enum logic [2:0] {
        ST_PAYLOAD,
        ST_ESC,
        ST_PROP,
        ST_START,
        ST_STOP,
        ST_REPLAY
    } state_t;

    typedef enum logic [1:0] {
        RUN_HOLD,
        RUN_CLEAR,
        RUN_SET1,
        RUN_INC
    } run_op_t;

    typedef enum logic [2:0] {
        EMIT_NONE,
        EMIT_IN,
        EMIT_ESC,
        EMIT_START,
        EMIT_FILL,
        EMIT_HELD,
        EMIT_END
    } emit_t;

    typedef struct packed {
        run_op_t    run_op;
        emit_t      emit;
        logic       last;
        logic       load_pad;
        logic       load_crc_hi;
        logic       capture;
        logic       fill_is_start;
        logic       fill_dec;
    } cmd_t;

    typedef struct packed {
        logic       is_esc;
        logic       is_start;
        logic       is_stop;
        logic       run_is_first;
        logic       run_is_last;
        logic       fill_zero;
        logic       out_free;
    } status_t;

endpackage

`default_nettype wire

// File: src/esd_datapath.sv
// ---------------------------------------------------------------------------
// esd_datapath
// Run counter, trailer stores, replay buffer and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module esd_datapath (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic [7:0]      in_byte,
    input  wire logic            out_stall,
    input  wire esd_pkg::cmd_t   cmd,
    output esd_pkg::status_t     status,
    output logic                 out_valid,
    output logic                 kind,
    output logic [7:0]           data_byte,
    output logic [7:0]           pad_count,
    output logic [15:0]          frame_crc,
    output logic                 last
);

    logic [1:0]  run_reg,       run_next;
    logic [7:0]  pad_reg,       pad_next;
    logic [7:0]  crc_hi_reg,    crc_hi_next;
    logic [7:0]  held_reg,      held_next;
    logic [7:0]  fill_reg,      fill_next;
    logic [1:0]  fill_left_reg, fill_left_next;
    logic        out_valid_reg, out_valid_next;
    logic        kind_reg,      kind_next;
    logic [7:0]  data_reg,      data_next;
    logic [7:0]  opad_reg,      opad_next;
    logic [15:0] ocrc_reg,      ocrc_next;
    logic        last_reg,      last_next;

    always_comb
    begin
        status.is_esc       = (in_byte == esd_pkg::ESC_BYTE);
        status.is_start     = (in_byte == esd_pkg::START_BYTE);
        status.is_stop      = (in_byte == esd_pkg::STOP_BYTE);
        status.run_is_first = (run_reg == 2'd1);
        status.run_is_last  = (run_reg == esd_pkg::RUN_LAST);
        status.fill_zero    = (fill_left_reg == 2'd0);
        status.out_free     = !out_valid_reg || !out_stall;
    end

    always_comb
    begin
        case (cmd.run_op)
            esd_pkg::RUN_CLEAR: run_next = 2'd0;
            esd_pkg::RUN_SET1:  run_next = 2'd1;
            esd_pkg::RUN_INC:   run_next = run_reg + 2'd1;
            default:            run_next = run_reg;
        endcase

        pad_next    = cmd.load_pad ? in_byte : pad_reg;
        crc_hi_next = cmd.load_crc_hi ? in_byte : crc_hi_reg;

        // On a broken run the first fill byte goes out at once; the rest of
        // the run and the breaking byte are replayed from these registers.
        held_next      = held_reg;
        fill_next      = fill_reg;
        fill_left_next = fill_left_reg;
        if (cmd.capture)
        begin
            held_next      = in_byte;
            fill_next      = cmd.fill_is_start ? esd_pkg::START_BYTE : esd_pkg::ESC_BYTE;
            fill_left_next = run_reg - 2'd1;
        end
        else if (cmd.fill_dec)
        begin
            fill_left_next = fill_left_reg - 2'd1;
        end
    end

    always_comb
    begin
        kind_next      = kind_reg;
        data_next      = data_reg;
        opad_next      = opad_reg;
        ocrc_next      = ocrc_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.emit != esd_pkg::EMIT_NONE)
        begin
            out_valid_next = 1'b1;
            kind_next      = 1'b0;
            opad_next      = 8'd0;
            ocrc_next      = 16'd0;
            last_next      = cmd.last;
            case (cmd.emit)
                esd_pkg::EMIT_IN:    data_next = in_byte;
                esd_pkg::EMIT_ESC:   data_next = esd_pkg::ESC_BYTE;
                esd_pkg::EMIT_START: data_next = esd_pkg::START_BYTE;
                esd_pkg::EMIT_FILL:  data_next = fill_reg;
                esd_pkg::EMIT_HELD:  data_next = held_reg;
                default:
                begin
                    kind_next = 1'b1;
                    data_next = 8'd0;
                    opad_next = pad_reg;
                    ocrc_next = {crc_hi_reg, in_byte};
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg       <= 2'd0;
            pad_reg       <= 8'd0;
            crc_hi_reg    <= 8'd0;
            fill_left_reg <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            run_reg       <= run_next;
            pad_reg       <= pad_next;
            crc_hi_reg    <= crc_hi_next;
            fill_left_reg <= fill_left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
        fill_reg <= fill_next;
        kind_reg <= kind_next;
        data_reg <= data_next;
        opad_reg <= opad_next;
        ocrc_reg <= ocrc_next;
        last_reg <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign data_byte = data_reg;
    assign pad_count = opad_reg;
    assign frame_crc = ocrc_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

// File: src/esd_ctrl.sv
// ---------------------------------------------------------------------------
// esd_ctrl
// Framing state machine: decodes escape, start and trailer sequences.
// ---------------------------------------------------------------------------
`default_nettype none

module esd_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire esd_pkg::status_t  status,
    output esd_pkg::cmd_t          cmd
);

    esd_pkg::state_t state_reg, state_next;
    logic            accept;

    assign in_stall = (state_reg == esd_pkg::ST_REPLAY) || !status.out_free;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            esd_pkg::ST_PAYLOAD:
            begin
                if (accept && status.is_esc)
                    state_next = esd_pkg::ST_ESC;
            end
            esd_pkg::ST_ESC:
            begin
                if (accept)
                begin
                    if (!status.is_esc)
                        state_next = esd_pkg::ST_REPLAY;
                    else if (status.run_is_last)
                        state_next = esd_pkg::ST_PROP;
                end
            end
            esd_pkg::ST_PROP:
            begin
                if (accept)
                begin
                    if (status.is_start)
                        state_next = esd_pkg::ST_START;
                    else if (status.is_stop)
                        state_next = esd_pkg::ST_STOP;
                    else if (status.is_esc)
                        state_next = esd_pkg::ST_ESC;
                    else
                        state_next = esd_pkg::ST_PAYLOAD;
                end
            end
            esd_pkg::ST_START:
            begin
                if (accept)
                begin
                    if (!status.is_start)
                        state_next = esd_pkg::ST_REPLAY;
                    else if (status.run_is_last)
                        state_next = esd_pkg::ST_PAYLOAD;
                end
            end
            esd_pkg::ST_STOP:
            begin
                if (accept && status.run_is_last)
                    state_next = esd_pkg::ST_PAYLOAD;
            end
            esd_pkg::ST_REPLAY:
            begin
                if (status.out_free && status.fill_zero)
                    state_next = esd_pkg::ST_PAYLOAD;
            end
            default:
            begin
                state_next = esd_pkg::ST_PAYLOAD;
            end
        endcase
    end

    always_comb
    begin
        cmd = '{run_op: esd_pkg::RUN_HOLD, emit: esd_pkg::EMIT_NONE, default: 1'b0};
        if (state_reg == esd_pkg::ST_REPLAY)
        begin
            if (status.out_free)
            begin
                if (status.fill_zero)
                begin
                    cmd.emit = esd_pkg::EMIT_HELD;
                    cmd.last = 1'b1;
                end
                else
                begin
                    cmd.emit     = esd_pkg::EMIT_FILL;
                    cmd.fill_dec = 1'b1;
                end
            end
        end
        else if (accept)
        begin
            unique case (state_reg)
                esd_pkg::ST_ESC:
                begin
                    if (status.is_esc)
                    begin
                        cmd.run_op = status.run_is_last ? esd_pkg::RUN_CLEAR : esd_pkg::RUN_INC;
                    end
                    else
                    begin
                        cmd.emit    = esd_pkg::EMIT_ESC;
                        cmd.capture = 1'b1;
                        cmd.run_op  = esd_pkg::RUN_CLEAR;
                    end
                end
                esd_pkg::ST_PROP:
                begin
                    if (status.is_start || status.is_stop || status.is_esc)
                    begin
                        cmd.run_op = esd_pkg::RUN_SET1;
                    end
                    else
                    begin
                        cmd.run_op = esd_pkg::RUN_CLEAR;
                        cmd.emit   = esd_pkg::EMIT_IN;
                        cmd.last   = 1'b1;
                    end
                end
                esd_pkg::ST_START:
                begin
                    if (status.is_start)
                    begin
                        cmd.run_op = status.run_is_last ? esd_pkg::RUN_CLEAR : esd_pkg::RUN_INC;
                    end
                    else
                    begin
                        cmd.emit          = esd_pkg::EMIT_START;
                        cmd.capture       = 1'b1;
                        cmd.fill_is_start = 1'b1;
                        cmd.run_op        = esd_pkg::RUN_CLEAR;
                    end
                end
                esd_pkg::ST_STOP:
                begin
                    // Trailer order: pad count, CRC high byte, CRC low byte.
                    if (status.run_is_last)
                    begin
                        cmd.emit   = esd_pkg::EMIT_END;
                        cmd.last   = 1'b1;
                        cmd.run_op = esd_pkg::RUN_CLEAR;
                    end
                    else
                    begin
                        cmd.run_op      = esd_pkg::RUN_INC;
                        cmd.load_pad    = status.run_is_first;
                        cmd.load_crc_hi = !status.run_is_first;
                    end
                end
                default:
                begin
                    if (status.is_esc)
                    begin
                        cmd.run_op = esd_pkg::RUN_SET1;
                    end
                    else
                    begin
                        cmd.emit = esd_pkg::EMIT_IN;
                        cmd.last = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= esd_pkg::ST_PAYLOAD;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

// File: src/escape_sequence_deframer.sv
// ---------------------------------------------------------------------------
// escape_sequence_deframer
// Strips escape framing from a byte stream and reports trailer contents.
//
//   Port group   Direction   Handshake            Contents
//   input        in          in_valid/in_stall    in_byte
//   output       out         out_valid/out_stall  kind, data_byte, pad_count,
//                                                 frame_crc, last
//
// One byte is taken per cycle while the result register is free.
// A broken escape or start run holds the input while the remaining run
// bytes and the breaking byte are replayed.
// Reset returns the framing state machine to payload mode and empties the
// result register. A stall on the output holds the result and, in turn,
// stalls the input.
// ---------------------------------------------------------------------------
`default_nettype none

module escape_sequence_deframer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  in_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             kind,
    output logic [7:0]       data_byte,
    output logic [7:0]       pad_count,
    output logic [15:0]      frame_crc,
    output logic             last
);

    esd_pkg::cmd_t    cmd;
    esd_pkg::status_t status;

    esd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    esd_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_byte   (in_byte),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .kind      (kind),
        .data_byte (data_byte),
        .pad_count (pad_count),
        .frame_crc (frame_crc),
        .last      (last)
    );

endmodule

`default_nettype wire

// File: bench/escape_sequence_deframer_tb.sv
// ---------------------------------------------------------------------------
// escape_sequence_deframer_tb
// Self-checking bench for the escape sequence deframer. A short table of
// framing corner cases is sent first, then a long run of random frames,
// broken runs and loose bytes. Every byte accepted at the input is fed to a
// behavioural model of the framing state machine, and every result transfer
// at the output is compared with the oldest result that model predicted.
// Both handshakes idle and stall at random.
// ---------------------------------------------------------------------------
`default_nettype none

module escape_sequence_deframer_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUN_BYTES     = 4;
    localparam int RANDOM_BYTES  = 334;
    localparam int IDLE_PERCENT  = 9;
    localparam int WATCHDOG      = 2000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int DIR_ROWS      = 26;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [7:0]  pad_count;
        logic [15:0] frame_crc;
        logic        last;
    } deframe_result_t;

    // One directed byte; where chk is set, the byte must cause n_res results
    // and the final one must carry the fields typed in the row.
    typedef struct packed {
        logic [7:0]  raw;
        logic        chk;
        logic [2:0]  n_res;
        logic        kind;
        logic [7:0]  data_byte;
        logic [7:0]  pad_count;
        logic [15:0] frame_crc;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  in_byte;
    logic        out_valid;
    logic        out_stall;
    logic        kind;
    logic [7:0]  data_byte;
    logic [7:0]  pad_count;
    logic [15:0] frame_crc;
    logic        last;

    // Framing model state.
    esd_pkg::state_t frame_mode = esd_pkg::ST_PAYLOAD;
    logic [2:0]      run_len    = 3'd0;
    logic [7:0]      pad_hold   = 8'h00;
    logic [15:0]     crc_hold   = 16'h0000;

    deframe_result_t step_q[$];
    deframe_result_t pending_q[$];
    int              fail_count = 0;
    int              random_sent = 0;
    bit              gaps_on = 1'b1;

    dir_row_t dir_rows [DIR_ROWS] = '{
        '{8'h00, 1'b1, 3'd1, 1'b0, 8'h00, 8'h00, 16'h0000},
        '{8'hff, 1'b1, 3'd1, 1'b0, 8'hff, 8'h00, 16'h0000},
        '{8'h1b, 1'b0, 3'd0, 1'b0, 8'h00, 8'h00, 16'h0000},
        '{8'h1b, 1'b0, 3'd0, 1'b0, 8'h00, 8'h00, 16'h0000},
        '{8'h1b, 1'b0, 3'd0, 1'b0, 8'h00, 8'h00, 16'h0000},
        '{8'h1b, 1'b1, 3'd0, 1'b0, 8'h00, 8'h00, 16'h0000},
        // An escape byte in the property slot opens a fresh escape run.
        '{8'h1b, 1'b1, 3'd0, 1'b0, 8'h00, 8'h00, 16'h0000},
        '{8'h1b, 1'b0, 3'd0, 1'b0, 8'h00, 8'h00, 16'h0000},
        '{8'h1b, 1'b0, 3'd0, 1'b0, 8'h00, 8'h00, 16'h0000},
        '{8'h1b, 1'b0, 3'd0, 1'b0, 8'h00, 8'h00, 16'h0000},
        '{8'h1a, 1'b1, 3'd0, 1'b0, 8'h00, 8'h00, 16'h0000},
        '{8'hff, 1'b0, 3'd0, 1'b0, 8'h00, 8'h00, 16'h0000},
        '{8'hff, 1'b0, 3'd0, 1'b0, 8'h00, 8'h00, 16'h0000},
        '{8'hff, 1'b1, 3'd1, 1'b1, 8'h00, 8'hff, 16'hffff},
        '{8'h1b, 1'b0, 3'd0, 1'b0, 8'h00, 8'h00, 16'h0000},
        '{8'h1b, 1'b0, 3'd0, 1'b0, 8'h00, 8'h00, 16'h0000},
        '{8'h1b, 1'b0, 3'd0, 1'b0, 8'h00, 8'h00, 16'h0000},
        '{8'h1b, 1'b0, 3'd0, 1'b0, 8'h00, 8'h00, 16'h0000},
        // Start run broken after three start bytes: all four bytes come back.
        '{8'h01, 1'b0, 3'd0, 1'b0, 8'h00, 8'h00, 16'h0000},
        '{8'h01, 1'b0, 3'd0, 1'b0, 8'h00, 8'h00, 16'h0000},
        '{8'h01, 1'b0, 3'd0, 1'b0, 8'h00, 8'h00, 16'h0000},
        '{8'h7f, 1'b1, 3'd4, 1'b0, 8'h7f, 8'h00, 16'h0000},
        // Escape run broken after three escape bytes.
        '{8'h1b, 1'b0, 3'd0, 1'b0, 8'h00, 8'h00, 16'h0000},
        '{8'h1b, 1'b0, 3'd0, 1'b0, 8'h00, 8'h00, 16'h0000},
        '{8'h1b, 1'b0, 3'd0, 1'b0, 8'h00, 8'h00, 16'h0000},
        '{8'h00, 1'b1, 3'd4, 1'b0, 8'h00, 8'h00, 16'h0000}
    };

    escape_sequence_deframer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .data_byte (data_byte),
        .pad_count (pad_count),
        .frame_crc (frame_crc),
        .last      (last)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void push_data(input logic [7:0] b);
        step_q.push_back('{1'b0, b, 8'h00, 16'h0000, 1'b0});
    endfunction

    // Payload handling, also used for a property byte that is not recognised.
    function automatic void payload_byte(input logic [7:0] c);
        if (c == esd_pkg::ESC_BYTE)
        begin
            run_len    = 3'd1;
            frame_mode = esd_pkg::ST_ESC;
        end
        else
        begin
            frame_mode = esd_pkg::ST_PAYLOAD;
            push_data(c);
        end
    endfunction

    // A run that broke off early: the bytes counted so far, then the breaker.
    function automatic void replay_run(input logic [7:0] fill, input logic [7:0] c);
        int cnt;
        cnt = (run_len > RUN_BYTES - 1) ? RUN_BYTES - 1 : run_len;
        for (int k = 0; k < cnt; k++)
            push_data(fill);
        push_data(c);
        run_len    = 3'd0;
        frame_mode = esd_pkg::ST_PAYLOAD;
    endfunction

    function automatic void predict_byte(input logic [7:0] c);
        step_q = {};
        case (frame_mode)
            esd_pkg::ST_ESC:
            begin
                if (c == esd_pkg::ESC_BYTE)
                begin
                    run_len = run_len + 3'd1;
                    if (run_len >= RUN_BYTES)
                    begin
                        run_len    = 3'd0;
                        frame_mode = esd_pkg::ST_PROP;
                    end
                end
                else
                    replay_run(esd_pkg::ESC_BYTE, c);
            end
            esd_pkg::ST_PROP:
            begin
                if (c == esd_pkg::START_BYTE)
                begin
                    run_len    = 3'd1;
                    frame_mode = esd_pkg::ST_START;
                end
                else if (c == esd_pkg::STOP_BYTE)
                begin
                    run_len    = 3'd1;
                    frame_mode = esd_pkg::ST_STOP;
                end
                else
                begin
                    run_len = 3'd0;
                    payload_byte(c);
                end
            end
            esd_pkg::ST_START:
            begin
                if (c == esd_pkg::START_BYTE)
                begin
                    run_len = run_len + 3'd1;
                    if (run_len >= RUN_BYTES)
                    begin
                        run_len    = 3'd0;
                        frame_mode = esd_pkg::ST_PAYLOAD;
                    end
                end
                else
                    replay_run(esd_pkg::START_BYTE, c);
            end
            esd_pkg::ST_STOP:
            begin
                if (run_len <= 3'd1)
                begin
                    pad_hold = c;
                    run_len  = 3'd2;
                end
                else if (run_len == 3'd2)
                begin
                    crc_hold = {c, 8'h00};
                    run_len  = 3'd3;
                end
                else
                begin
                    crc_hold   = {crc_hold[15:8], c};
                    run_len    = 3'd0;
                    frame_mode = esd_pkg::ST_PAYLOAD;
                    step_q.push_back('{1'b1, 8'h00, pad_hold, crc_hold, 1'b0});
                end
            end
            default:
                payload_byte(c);
        endcase
        if (step_q.size() > 0)
            step_q[step_q.size() - 1].last = 1'b1;
        foreach (step_q[i])
            pending_q.push_back(step_q[i]);
    endfunction

    // Drives one byte and returns after its transfer. The stall is sampled
    // on the falling edge, where it already holds the value seen by the next
    // rising edge.
    task automatic send_byte(input logic [7:0] b);
        while (gaps_on && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        @(negedge clk);
        while (in_stall)
        begin
            @(posedge clk);
            @(negedge clk);
        end
        predict_byte(b);
        @(posedge clk);
    endtask

    function automatic logic [7:0] pick_byte();
        logic [7:0] b;
        case ($urandom_range(0, 15))
            0:       b = esd_pkg::ESC_BYTE;
            1:       b = esd_pkg::START_BYTE;
            2:       b = esd_pkg::STOP_BYTE;
            3:       b = 8'h00;
            4:       b = 8'hff;
            default: b = 8'($urandom_range(0, 255));
        endcase
        return b;
    endfunction

    task automatic send_escape_run();
        for (int k = 0; k < RUN_BYTES; k++)
            send_byte(esd_pkg::ESC_BYTE);
    endtask

    task automatic send_random_group();
        int         choice;
        int         count;
        logic [7:0] b;
        choice = $urandom_range(0, 99);
        if (choice < 55)
        begin
            send_escape_run();
            for (int k = 0; k < RUN_BYTES; k++)
                send_byte(esd_pkg::START_BYTE);
            count = $urandom_range(1, 8);
            for (int k = 0; k < count; k++)
                send_byte(pick_byte());
            send_escape_run();
            send_byte(esd_pkg::STOP_BYTE);
            send_byte(8'($urandom_range(0, 255)));
            send_byte(8'($urandom_range(0, 255)));
            send_byte(8'($urandom_range(0, 255)));
            random_sent += count + 2 * RUN_BYTES + 4 + RUN_BYTES;
        end
        else if (choice < 65)
        begin
            count = $urandom_range(1, RUN_BYTES - 1);
            for (int k = 0; k < count; k++)
                send_byte(esd_pkg::ESC_BYTE);
            do
                b = pick_byte();
            while (b == esd_pkg::ESC_BYTE);
            send_byte(b);
            random_sent += count + 1;
        end
        else if (choice < 75)
        begin
            send_escape_run();
            count = $urandom_range(1, RUN_BYTES - 1);
            for (int k = 0; k < count; k++)
                send_byte(esd_pkg::START_BYTE);
            do
                b = pick_byte();
            while (b == esd_pkg::START_BYTE);
            send_byte(b);
            random_sent += RUN_BYTES + count + 1;
        end
        else if (choice < 83)
        begin
            send_escape_run();
            do
                b = pick_byte();
            while (b == esd_pkg::START_BYTE || b == esd_pkg::STOP_BYTE);
            send_byte(b);
            random_sent += RUN_BYTES + 1;
        end
        else
        begin
            count = $urandom_range(1, 6);
            for (int k = 0; k < count; k++)
                send_byte(pick_byte());
            random_sent += count;
        end
    endtask

    function automatic void check_result(input deframe_result_t got);
        deframe_result_t want;
        if (pending_q.size() == 0)
        begin
            $error("unexpected result transfer: kind %0d data %02h pad %02h crc %04h last %0d",
                   got.kind, got.data_byte, got.pad_count, got.frame_crc, got.last);
            fail_count++;
            return;
        end
        want = pending_q.pop_front();
        if (got.kind !== want.kind)
        begin
            $error("kind: expected %0d, got %0d", want.kind, got.kind);
            fail_count++;
        end
        if (got.data_byte !== want.data_byte)
        begin
            $error("data_byte: expected %02h, got %02h", want.data_byte, got.data_byte);
            fail_count++;
        end
        if (got.pad_count !== want.pad_count)
        begin
            $error("pad_count: expected %02h, got %02h", want.pad_count, got.pad_count);
            fail_count++;
        end
        if (got.frame_crc !== want.frame_crc)
        begin
            $error("frame_crc: expected %04h, got %04h", want.frame_crc, got.frame_crc);
            fail_count++;
        end
        if (got.last !== want.last)
        begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            fail_count++;
        end
    endfunction

    // Result side: stall at random, check each transfer on the falling edge.
    initial
    begin : result_side
        out_stall <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (rst_n && out_valid && !out_stall)
                check_result({kind, data_byte, pad_count, frame_crc, last});
            @(posedge clk);
            out_stall <= gaps_on && ($urandom_range(0, 99) < IDLE_PERCENT);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG)
        begin
            @(negedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $error("no transfer for %0d cycles", WATCHDOG);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : stimulus
        dir_row_t        row;
        deframe_result_t typed;
        bit              paused;
        paused   = 1'b0;
        rst_n    = 1'b0;
        in_valid <= 1'b0;
        in_byte  <= 8'h00;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIR_ROWS; r++)
        begin
            row = dir_rows[r];
            send_byte(row.raw);
            if (row.chk)
            begin
                typed = '{row.kind, row.data_byte, row.pad_count, row.frame_crc, 1'b1};
                if (step_q.size() != row.n_res)
                begin
                    $error("row %0d result count: expected %0d, got %0d",
                           r, row.n_res, step_q.size());
                    fail_count++;
                end
                else if (row.n_res != 0 && step_q[step_q.size() - 1] != typed)
                begin
                    $error("row %0d final result: expected %h, got %h",
                           r, typed, step_q[step_q.size() - 1]);
                    fail_count++;
                end
            end
        end

        while (random_sent < RANDOM_BYTES)
        begin
            // A stretch in the middle runs with no random idling on either side.
            gaps_on = !(random_sent >= 100 && random_sent < 220);
            if (!paused && random_sent >= 180)
            begin
                in_valid <= 1'b0;
                while (pending_q.size() != 0)
                    @(posedge clk);
                @(posedge clk);
                paused = 1'b1;
            end
            send_random_group();
        end
        gaps_on = 1'b1;
        in_valid <= 1'b0;

        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
src/esd_pkg.sv
src/esd_datapath.sv
src/esd_ctrl.sv
src/escape_sequence_deframer.sv
bench/escape_sequence_deframer_tb.sv
